// ----- hw/rtl/lrm_pkg.sv -----
// ============================================================================
// lrm_pkg
// Shared types, register map, waveform codes and the quarter-wave sine table
// for the LFO ring modulator.
// ============================================================================
package lrm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_BITS      = 32;
    localparam int MOD_BITS       = 18;
    localparam int SINE_DEPTH     = 256;
    localparam int SINE_IDX_BITS  = $clog2(SINE_DEPTH);
    localparam int SINE_ADDR_BITS = SINE_IDX_BITS + 1;
    localparam int SINE_VAL_BITS  = 17;

    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0] SINE_DEPTH_W = 64'(SINE_DEPTH);

    // unity gain in Q2.30, used for bypass
    localparam logic signed [GAIN_BITS-1:0] GAIN_ONE = 32'sd1073741824;

    localparam logic [15:0] BLEND_FULL = 16'd32768;

    // register map (word index)
    localparam logic [1:0] REG_PHASE_INC = 2'd0;
    localparam logic [1:0] REG_BLEND     = 2'd1;
    localparam logic [1:0] REG_WAVEFORM  = 2'd2;
    localparam logic [1:0] REG_BYPASS    = 2'd3;

    // waveform codes
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SQUARE   = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } lrm_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } lrm_out_t;

    typedef struct packed {
        logic [23:0] phase_increment;
        logic [15:0] blend;
        logic [1:0]  waveform;
        logic        bypass;
    } lrm_cfg_t;

    // one classified transaction handed from front to back
    typedef struct packed {
        lrm_in_t                       samples;
        logic signed [GAIN_BITS-1:0]   gain;
    } lrm_work_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_GAIN,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LEFT,
        B_RIGHT,
        B_PUSH
    } back_state_t;

    typedef logic [SINE_VAL_BITS-1:0] sine_tab_t [SINE_DEPTH+1];

    function automatic logic [63:0] sq_mul(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // 32768*sin(pi/2*k/D) from a Taylor series in Q30
    function automatic logic [SINE_VAL_BITS-1:0] sine_entry(input logic [63:0] k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        x    = (HALF_PI_Q30 * k) / SINE_DEPTH_W;
        term = x;
        sum  = $signed(x);
        term = sq_mul(term, x) / 64'd6;
        sum  = sum - $signed(term);
        term = sq_mul(term, x) / 64'd20;
        sum  = sum + $signed(term);
        term = sq_mul(term, x) / 64'd42;
        sum  = sum - $signed(term);
        term = sq_mul(term, x) / 64'd72;
        sum  = sum + $signed(term);
        term = sq_mul(term, x) / 64'd110;
        sum  = sum - $signed(term);
        term = sq_mul(term, x) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (sum + 64'sd16384) >>> 15;
        if (r > 64'sd32768)
        begin
            r = 64'sd32768;
        end
        return r[SINE_VAL_BITS-1:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            tab[k] = sine_entry(64'(k));
        end
        tab[SINE_DEPTH] = 17'd32768;
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ----- hw/rtl/lrm_fifo.sv -----
// ============================================================================
// lrm_fifo
// Small register-based FIFO used between front and back and on the result
// side.
// ============================================================================
module lrm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [AW:0]      count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("fifo occupancy above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("fifo write lost");
`endif

endmodule

// ----- hw/rtl/lrm_front.sv -----
// ============================================================================
// lrm_front
// Accepts sample pairs, looks up the LFO value from the phase, forms the
// channel gain (unity on bypass) and advances the phase unless bypassed.
// ============================================================================
module lrm_front #(
    parameter int PHASE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lrm_pkg::lrm_cfg_t cfg,
    input  logic              push,
    output logic              full,
    input  lrm_pkg::lrm_in_t  sample,
    input  logic              q_full,
    output logic              q_push,
    output lrm_pkg::lrm_work_t q_data
);

    import lrm_pkg::*;

    front_state_t                  state_reg;
    front_state_t                  state_next;
    logic [PHASE_BITS-1:0]         phase_reg;
    logic [PHASE_BITS-1:0]         phase_next;
    lrm_in_t                       smp_reg;
    logic                          byp_reg;
    logic signed [MOD_BITS-1:0]    mod_reg;
    logic signed [GAIN_BITS-1:0]   gain_reg;

    logic                          accept;
    logic [31:0]                   inc32;
    logic [PHASE_BITS-1:0]         inc_step;
    logic [1:0]                    quad;
    logic [SINE_IDX_BITS-1:0]      sidx;
    logic [SINE_ADDR_BITS-1:0]     sidx_rev;
    logic [SINE_VAL_BITS-1:0]      sine_a;
    logic [SINE_VAL_BITS-1:0]      sine_b;
    logic signed [18:0]            tri_v;
    logic signed [18:0]            tri_f;
    logic signed [MOD_BITS-1:0]    mod_val;
    logic [15:0]                   blend_c;
    logic [15:0]                   dry;
    logic signed [34:0]            wet;
    logic signed [GAIN_BITS-1:0]   gain_val;

    assign accept   = push && !full;
    assign inc32    = {8'd0, cfg.phase_increment};
    assign inc_step = inc32[31 -: PHASE_BITS];

    assign quad     = phase_reg[PHASE_BITS-1 -: 2];
    assign sidx     = phase_reg[PHASE_BITS-3 -: SINE_IDX_BITS];
    assign sidx_rev = SINE_ADDR_BITS'(SINE_DEPTH) - {1'b0, sidx};
    assign sine_a   = SINE_TAB[{1'b0, sidx}];
    assign sine_b   = SINE_TAB[sidx_rev];

    always_comb
    begin
        tri_v = {2'b00, phase_reg[PHASE_BITS-1 -: 17]};
        if (tri_v > 19'sd32768)
        begin
            tri_v = 19'sd65536 - tri_v;
        end
        tri_f = tri_v;
        if (tri_v < -19'sd32768)
        begin
            tri_f = -19'sd65536 - tri_v;
        end
    end

    always_comb
    begin
        case (cfg.waveform)
            WAVE_SINE:
            begin
                case (quad)
                    2'd0:    mod_val = $signed({1'b0, sine_a});
                    2'd1:    mod_val = $signed({1'b0, sine_b});
                    2'd2:    mod_val = -$signed({1'b0, sine_a});
                    default: mod_val = -$signed({1'b0, sine_b});
                endcase
            end
            WAVE_TRIANGLE: mod_val = tri_f[MOD_BITS-1:0];
            WAVE_SQUARE:   mod_val = phase_reg[PHASE_BITS-1] ? -18'sd32768 : 18'sd32768;
            default:       mod_val = '0;
        endcase
    end

    assign blend_c  = (cfg.blend > BLEND_FULL) ? BLEND_FULL : cfg.blend;
    assign dry      = BLEND_FULL - blend_c;
    assign wet      = $signed({1'b0, blend_c}) * mod_reg;
    assign gain_val = $signed({1'b0, dry, 15'd0}) + $signed(wet[GAIN_BITS-1:0]);

    assign phase_next = (accept && !cfg.bypass) ? phase_reg + inc_step : phase_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (push) state_next = F_GAIN;
            F_GAIN: state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        full   = (state_reg != F_IDLE);
        q_push = (state_reg == F_PUSH) && !q_full;
    end

    assign q_data = '{samples: smp_reg, gain: gain_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_reg <= sample;
            byp_reg <= cfg.bypass;
            mod_reg <= mod_val;
        end
        if (state_reg == F_GAIN)
        begin
            gain_reg <= byp_reg ? GAIN_ONE : gain_val;
        end
    end

`ifndef SYNTH
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cfg.bypass) |=> $stable(phase_reg))
        else $error("phase moved on bypass");

    a_bypass_unity: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && byp_reg) |-> (q_data.gain == GAIN_ONE))
        else $error("bypass transaction without unity gain");
`endif

endmodule

// ----- hw/rtl/lrm_back.sv -----
// ============================================================================
// lrm_back
// Applies the gain to both channels through one shared multiplier and
// saturates the single overflow case.
// ============================================================================
module lrm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  lrm_pkg::lrm_work_t q_data,
    output logic               q_pop,
    input  logic               out_full,
    output logic               out_push,
    output lrm_pkg::lrm_out_t  out_data
);

    import lrm_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
    localparam int Y_BITS    = SAMPLE_BITS + 2;

    back_state_t                    state_reg;
    back_state_t                    state_next;
    lrm_work_t                      work_reg;
    logic signed [PROD_BITS-1:0]    prod_reg;
    logic signed [SAMPLE_BITS-1:0]  left_res_reg;

    logic signed [SAMPLE_BITS-1:0]  opnd;
    logic signed [PROD_BITS-1:0]    prod_next;
    logic signed [Y_BITS-1:0]       y_full;
    logic signed [SAMPLE_BITS-1:0]  y_sat;

    assign opnd      = (state_reg == B_LEFT) ? work_reg.samples.left_in
                                             : work_reg.samples.right_in;
    assign prod_next = opnd * work_reg.gain;

    // product >>> 30, sign bits included
    assign y_full = prod_reg[PROD_BITS-1 -: Y_BITS];
    assign y_sat  = (y_full > $signed({3'b000, {(SAMPLE_BITS-1){1'b1}}}))
                  ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                  : y_full[SAMPLE_BITS-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!q_empty && !out_full) state_next = B_LEFT;
            B_LEFT:  state_next = B_RIGHT;
            B_RIGHT: state_next = B_PUSH;
            B_PUSH:  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop    = (state_reg == B_IDLE) && !q_empty && !out_full;
        out_push = (state_reg == B_PUSH);
    end

    assign out_data = '{left_out: left_res_reg, right_out: y_sat};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            work_reg <= q_data;
        end
        if (state_reg == B_LEFT || state_reg == B_RIGHT)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == B_RIGHT)
        begin
            left_res_reg <= y_sat;
        end
    end

`ifndef SYNTH
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result queue full on push");

    a_push_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> $past(q_pop, 3))
        else $error("result without a popped transaction");
`endif

endmodule

// ----- hw/rtl/lfo_ring_modulator.sv -----
// ============================================================================
// lfo_ring_modulator
// The back end sets the throughput, running both channels through one shared
// multiplier; neither the front end nor the back end takes a new stereo pair
// before it has passed on the last one.
// Reset (rst_n, async low): queues empty, phase zero, registers to defaults.
// ============================================================================
module lfo_ring_modulator #(
    parameter int PHASE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  lrm_pkg::lrm_in_t  sample,
    output logic              empty,
    input  logic              pop,
    output lrm_pkg::lrm_out_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    import lrm_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    lrm_cfg_t  cfg_reg;
    logic      cfg_wr;
    logic [1:0] reg_idx;

    logic      mid_full;
    logic      mid_push;
    lrm_work_t mid_wdata;
    logic      mid_empty;
    logic      mid_pop;
    logic [$bits(lrm_work_t)-1:0] mid_rdata;

    logic      out_full;
    logic      out_push;
    lrm_out_t  out_wdata;
    logic [$bits(lrm_out_t)-1:0] out_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_increment <= 24'd568188;
            cfg_reg.blend           <= 16'd16384;
            cfg_reg.waveform        <= WAVE_SINE;
            cfg_reg.bypass          <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_PHASE_INC: cfg_reg.phase_increment <= pwdata[23:0];
                REG_BLEND:     cfg_reg.blend           <= pwdata[15:0];
                REG_WAVEFORM:  cfg_reg.waveform        <= pwdata[1:0];
                REG_BYPASS:    cfg_reg.bypass          <= pwdata[0];
                default:       cfg_reg.bypass          <= cfg_reg.bypass;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PHASE_INC: prdata = {8'd0, cfg_reg.phase_increment};
            REG_BLEND:     prdata = {16'd0, cfg_reg.blend};
            REG_WAVEFORM:  prdata = {30'd0, cfg_reg.waveform};
            REG_BYPASS:    prdata = {31'd0, cfg_reg.bypass};
            default:       prdata = '0;
        endcase
    end

    lrm_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .full   (full),
        .sample (sample),
        .q_full (mid_full),
        .q_push (mid_push),
        .q_data (mid_wdata)
    );

    lrm_fifo #(
        .WIDTH ($bits(lrm_work_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .rd    (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    lrm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (mid_empty),
        .q_data   (lrm_work_t'(mid_rdata)),
        .q_pop    (mid_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_data (out_wdata)
    );

    lrm_fifo #(
        .WIDTH ($bits(lrm_out_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .rd    (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign result = lrm_out_t'(out_rdata);

endmodule
